// File: design/cfds_pkg.sv
// Package for the closest-fraction denominator selector.
// Holds the field widths, arithmetic constants, state codes and unit request types.
// No dependencies; every other design file but cfds_ram imports it.
package cfds_pkg;

    localparam int CFG_BITS      = 5;
    localparam int IDX_BITS      = 4;
    localparam int DENOM_BITS    = 16;
    localparam int FRACTION_BITS = 32;
    localparam int LCM_BITS      = 32;
    localparam int DIST_BITS     = 31;
    localparam int DIV_BITS      = 48;
    localparam int PROD_BITS     = 2 * LCM_BITS;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [PROD_BITS-1:0] LCM_MAX  = PROD_BITS'(64'hFFFF_FFFF);
    localparam logic [PROD_BITS-1:0] RND_ADD  = PROD_BITS'(64'h1) << (FRACTION_BITS - 1);
    localparam logic [PROD_BITS-1:0] HALF_LIM = PROD_BITS'(64'h1) << (FRACTION_BITS - 1);
    localparam logic [PROD_BITS-1:0] TWO_LIM  = PROD_BITS'(64'h1) << (FRACTION_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ZRD,
        S_ZCHK,
        S_L0RD,
        S_L0,
        S_LRD,
        S_LGST,
        S_LGCD,
        S_LDIV,
        S_LMUL,
        S_LCHK,
        S_NMUL,
        S_NUM,
        S_DRD,
        S_DMUL,
        S_DDST,
        S_DDIV,
        S_TRD,
        S_TA,
        S_TB,
        S_TC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                start;
        logic [LCM_BITS-1:0] a;
        logic [LCM_BITS-1:0] b;
    } t_gcd_req;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [LCM_BITS-1:0] divisor;
    } t_div_req;

endpackage

// File: design/cfds_channels.sv
// Handshake channel interfaces of the selector: query input, result output, config write.
// Depends on cfds_pkg for the field widths.
interface cfds_query_if;
    import cfds_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [IDX_BITS-1:0]      entry_index;
    logic [DENOM_BITS-1:0]    denominator;
    logic [FRACTION_BITS-1:0] fraction_value;
    modport source (output valid, opcode, entry_index, denominator, fraction_value,
                    input ready);
    modport sink (input valid, opcode, entry_index, denominator, fraction_value,
                  output ready);
endinterface

interface cfds_result_if;
    import cfds_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [IDX_BITS-1:0]  winner_index;
    logic [LCM_BITS-1:0]  common_multiple;
    logic [DIST_BITS-1:0] best_distance;
    logic                 overflow_flag;
    modport source (output valid, winner_index, common_multiple, best_distance,
                    overflow_flag, input ready);
    modport sink (input valid, winner_index, common_multiple, best_distance,
                  overflow_flag, output ready);
endinterface

interface cfds_cfg_if;
    import cfds_pkg::*;
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] active_entries;
    modport source (output valid, active_entries, input ready);
    modport sink (input valid, active_entries, output ready);
endinterface

// File: design/cfds_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module cfds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/cfds_gcd.sv
// Binary GCD unit: one shift or subtract step per cycle, pulses o_done with the result.
// Depends on cfds_pkg for widths and the request type.
module cfds_gcd (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfds_pkg::t_gcd_req            i_req,
    output logic                          o_done,
    output logic [cfds_pkg::LCM_BITS-1:0] o_gcd
);
    import cfds_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [LCM_BITS-1:0] r_a;
    logic [LCM_BITS-1:0] r_b;
    logic [LCM_BITS-1:0] r_gcd;
    logic [5:0]          r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_sh   <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a == r_b) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_gcd  <= r_a << r_sh;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a  <= r_a >> 1;
                    r_b  <= r_b >> 1;
                    r_sh <= r_sh + 6'd1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a > r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_gcd;
endmodule

// File: design/cfds_div.sv
// Restoring divider, one quotient bit per cycle over the full dividend width.
// Depends on cfds_pkg for widths and the request type.
module cfds_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfds_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [cfds_pkg::DIV_BITS-1:0] o_quot,
    output logic [cfds_pkg::LCM_BITS-1:0] o_rem
);
    import cfds_pkg::*;

    localparam int CNT_BITS = $clog2(DIV_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0] r_dvd;
    logic [LCM_BITS-1:0] r_rem;
    logic [LCM_BITS-1:0] r_dsr;
    logic [LCM_BITS:0]   shifted;
    logic [LCM_BITS:0]   diff;
    logic                fits;

    assign shifted = {r_rem, r_dvd[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, r_dsr};
    assign fits    = shifted >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // The quotient bits shift in behind the dividend bits.
                r_rem <= fits ? diff[LCM_BITS-1:0] : shifted[LCM_BITS-1:0];
                r_dvd <= {r_dvd[DIV_BITS-2:0], fits};
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;
endmodule

// File: design/closest_fraction_denominator_select_top.sv
// A query runs the GCD unit and the divider once for each active entry after the first while
// it builds the LCM, then the divider once more for each entry that it scans. Queries are
// handled one at a time; a new word is taken once the previous result sits in the output
// register.
// Depends on cfds_pkg, cfds_channels, cfds_ram, cfds_gcd and cfds_div.
module closest_fraction_denominator_select_top #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cfds_cfg_if.sink      i_cfg_ch,
    cfds_query_if.sink    i_query_ch,
    cfds_result_if.source o_result_ch
);
    import cfds_pkg::*;

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int NW = IW + 1;

    t_state r_state;
    t_state n_state;

    logic [CFG_BITS-1:0]      r_active;
    logic [NW-1:0]            r_n;
    logic [NW-1:0]            r_idx;
    logic [NW-1:0]            r_win;
    logic [FRACTION_BITS-1:0] r_frac;
    logic [LCM_BITS-1:0]      r_lcm;
    logic [LCM_BITS-1:0]      r_q;
    logic [LCM_BITS-1:0]      r_num;
    logic [DENOM_BITS-1:0]    r_d;
    logic [LCM_BITS:0]        r_best;
    logic                     r_zero_res;
    logic                     r_ovf_res;
    logic                     r_eq;
    logic [PROD_BITS-1:0]     r_prod;
    logic [LCM_BITS-1:0]      mul_a;
    logic [LCM_BITS-1:0]      mul_b;

    logic                     r_ovalid;
    logic [IDX_BITS-1:0]      r_o_win;
    logic [LCM_BITS-1:0]      r_o_lcm;
    logic [DIST_BITS-1:0]     r_o_dist;
    logic                     r_o_ovf;

    logic                     we;
    logic [IW-1:0]            waddr;
    logic [IW-1:0]            raddr;
    logic [DENOM_BITS-1:0]    rdata;

    t_gcd_req                 gcd_req;
    logic                     gcd_done;
    logic [LCM_BITS-1:0]      gcd_val;
    t_div_req                 div_req;
    logic                     div_done;
    logic [DIV_BITS-1:0]      div_quot;
    logic [LCM_BITS-1:0]      div_rem;

    logic                     accept_q;
    logic                     is_last;
    logic [NW-1:0]            n_eff;
    logic [LCM_BITS-1:0]      t_alt;
    logic [LCM_BITS-1:0]      t_fold;
    logic                     t_better;
    logic                     scan_end;
    logic [NW-1:0]            win_next;
    logic                     out_free;
    logic                     lcm_ovf;
    logic                     normal_res;
    logic [PROD_BITS-1:0]     num_sum;
    logic [LCM_BITS-1:0]      num_raw;

    cfds_ram #(
        .WIDTH (DENOM_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_query_ch.denominator),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    cfds_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (gcd_req),
        .o_done  (gcd_done),
        .o_gcd   (gcd_val)
    );

    cfds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign i_cfg_ch.ready   = 1'b1;
    assign i_query_ch.ready = (r_state == S_IDLE);
    assign accept_q         = i_query_ch.valid && i_query_ch.ready;

    assign we    = accept_q && (i_query_ch.opcode == OP_WRITE) &&
                   (32'(i_query_ch.entry_index) < MAX_ENTRIES);
    assign waddr = IW'(i_query_ch.entry_index);

    always_comb begin
        if (r_active == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_active) > MAX_ENTRIES) begin
            n_eff = NW'(MAX_ENTRIES);
        end else begin
            n_eff = NW'(r_active);
        end
    end

    assign is_last    = (r_idx == r_n - NW'(1));
    assign t_alt      = r_lcm - div_rem;
    assign t_fold     = (t_alt < div_rem) ? t_alt : div_rem;
    assign t_better   = {1'b0, t_fold} < r_best;
    // An exact hit ends the scan early.
    assign scan_end   = (t_better && (t_fold == '0)) || is_last;
    assign win_next   = r_win + NW'(1);
    assign out_free   = !r_ovalid || o_result_ch.ready;
    assign lcm_ovf    = r_prod > LCM_MAX;
    assign normal_res = !r_zero_res && !r_ovf_res;
    assign num_sum    = r_prod + RND_ADD;
    assign num_raw    = num_sum[PROD_BITS-1:FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        raddr   = r_idx[IW-1:0];
        gcd_req = '0;
        div_req = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept_q && (i_query_ch.opcode == OP_QUERY)) begin
                    n_state = S_ZRD;
                end
            end
            S_ZRD: n_state = S_ZCHK;
            S_ZCHK: begin
                if (rdata == '0) begin
                    n_state = S_DONE;
                end else if (is_last) begin
                    n_state = S_L0RD;
                end else begin
                    n_state = S_ZRD;
                end
            end
            S_L0RD: begin
                raddr   = '0;
                n_state = S_L0;
            end
            S_L0: n_state = (r_n == NW'(1)) ? S_NMUL : S_LRD;
            S_LRD: n_state = S_LGST;
            S_LGST: begin
                gcd_req.start = 1'b1;
                gcd_req.a     = r_lcm;
                gcd_req.b     = LCM_BITS'(rdata);
                n_state       = S_LGCD;
            end
            S_LGCD: begin
                if (gcd_done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_BITS'(r_lcm);
                    div_req.divisor  = gcd_val;
                    n_state          = S_LDIV;
                end
            end
            S_LDIV: begin
                if (div_done) begin
                    n_state = S_LMUL;
                end
            end
            S_LMUL: begin
                mul_a   = r_q;
                mul_b   = LCM_BITS'(r_d);
                n_state = S_LCHK;
            end
            S_LCHK: begin
                if (lcm_ovf) begin
                    n_state = S_DONE;
                end else if (is_last) begin
                    n_state = S_NMUL;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_NMUL: begin
                mul_a   = r_lcm;
                mul_b   = r_frac;
                n_state = S_NUM;
            end
            S_NUM: n_state = S_DRD;
            S_DRD: n_state = S_DMUL;
            S_DMUL: begin
                mul_a   = r_num;
                mul_b   = LCM_BITS'(rdata);
                n_state = S_DDST;
            end
            S_DDST: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod[DIV_BITS-1:0];
                div_req.divisor  = r_lcm;
                n_state          = S_DDIV;
            end
            S_DDIV: begin
                if (div_done) begin
                    n_state = scan_end ? S_TRD : S_DRD;
                end
            end
            S_TRD: begin
                raddr   = r_win[IW-1:0];
                n_state = (win_next < r_n) ? S_TA : S_DONE;
            end
            S_TA: begin
                raddr   = win_next[IW-1:0];
                n_state = S_TB;
            end
            S_TB: begin
                mul_a   = LCM_BITS'(r_d);
                mul_b   = r_frac;
                n_state = S_TC;
            end
            S_TC: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Shared multiplier; each product is used in the cycle after it is formed.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept_q) begin
                    r_frac     <= i_query_ch.fraction_value;
                    r_n        <= n_eff;
                    r_idx      <= '0;
                    r_zero_res <= 1'b0;
                    r_ovf_res  <= 1'b0;
                end
            end
            S_ZCHK: begin
                if (rdata == '0) begin
                    r_zero_res <= 1'b1;
                end else if (is_last) begin
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + NW'(1);
                end
            end
            S_L0: begin
                r_lcm <= LCM_BITS'(rdata);
                r_idx <= NW'(1);
            end
            S_LGST: r_d <= rdata;
            S_LDIV: begin
                if (div_done) begin
                    r_q <= div_quot[LCM_BITS-1:0];
                end
            end
            S_LCHK: begin
                if (lcm_ovf) begin
                    r_ovf_res <= 1'b1;
                end else begin
                    r_lcm <= r_prod[LCM_BITS-1:0];
                    if (!is_last) begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
            end
            S_NUM: begin
                // The rounded numerator is at most the LCM, so the modulo is one compare.
                r_num  <= (num_raw == r_lcm) ? '0 : num_raw;
                r_idx  <= '0;
                r_best <= '1;
                r_win  <= '0;
            end
            S_DDIV: begin
                if (div_done) begin
                    if (t_better) begin
                        r_best <= {1'b0, t_fold};
                        r_win  <= r_idx;
                    end
                    if (!scan_end) begin
                        r_idx <= r_idx + NW'(1);
                    end
                end
            end
            S_TA: r_d <= rdata;
            S_TB: r_eq <= (rdata == r_d);
            S_TC: begin
                if (r_eq && ((r_prod < HALF_LIM) || (r_prod >= TWO_LIM))) begin
                    r_win <= win_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_BITS'(1);
        end else if (i_cfg_ch.valid) begin
            r_active <= i_cfg_ch.active_entries;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_o_win  <= normal_res ? IDX_BITS'(r_win) : '0;
            r_o_lcm  <= normal_res ? r_lcm : '0;
            r_o_dist <= normal_res ? r_best[DIST_BITS-1:0] : '0;
            r_o_ovf  <= r_ovf_res;
        end
    end

    assign o_result_ch.valid           = r_ovalid;
    assign o_result_ch.winner_index    = r_o_win;
    assign o_result_ch.common_multiple = r_o_lcm;
    assign o_result_ch.best_distance   = r_o_dist;
    assign o_result_ch.overflow_flag   = r_o_ovf;

`ifndef SYNTHESIS
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_ovf) |-> (r_o_win == '0 && r_o_lcm == '0 && r_o_dist == '0))
        else $error("overflow result carries nonzero fields");

    a_dist_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_o_ovf) |-> ({1'b0, r_o_dist, 1'b0} <= {1'b0, r_o_lcm}))
        else $error("best distance exceeds half the LCM");

    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_zero_res && !r_ovf_res) |-> (r_win < r_n))
        else $error("winner outside the active entries");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("result word raised outside the done state");
`endif
endmodule
